/* sv/exposure_gain_code_convert_top_assert.svh */
// Assertion macros for the exposure and gain code converter.
`ifndef EXPOSURE_GAIN_CODE_CONVERT_TOP_ASSERT_SVH
`define EXPOSURE_GAIN_CODE_CONVERT_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define EGC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define EGC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/egc_pkg.sv */
// Shared types and constants of the exposure and gain code converter.
package egc_pkg;

  localparam logic [15:0] LINE_MAX  = 16'hFFFF;
  localparam logic [15:0] LINE_MIN  = 16'd2;
  localparam logic [15:0] RATIO_MAX = 16'hFFFF;
  localparam logic [14:0] GAIN_LOW  = 15'd200;
  localparam logic [14:0] GAIN_HIGH = 15'd24000;
  localparam logic [14:0] GAIN_B1   = 15'd2000;
  localparam logic [14:0] GAIN_B2   = 15'd4000;
  localparam logic [14:0] GAIN_B3   = 15'd8000;
  localparam logic [14:0] GAIN_B4   = 15'd12000;
  localparam logic [11:0] RANGE_X1  = 12'h200;
  localparam logic [11:0] RANGE_X2  = 12'h280;
  localparam logic [11:0] RANGE_X4  = 12'h480;
  localparam logic [11:0] RANGE_X6  = 12'h680;
  localparam logic [11:0] RANGE_X12 = 12'hC80;
  localparam logic [11:0] CODE_TOP  = 12'hDFF;
  // floor(n/3) = (n*RECIP3)>>17 for n below 2^15
  localparam logic [15:0] RECIP3    = 16'd43691;
  // floor(n/125) = (n*RECIP125)>>24 for n below 2^17
  localparam logic [17:0] RECIP125  = 18'd134218;

  localparam int CFG_IDX_W = 8;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_CLOCK = 8'd0,
    CFG_LINE_TOTAL  = 8'd1,
    CFG_AGC_BASE    = 8'd2,
    CFG_ISO_BASE    = 8'd3
  } egc_cfg_idx_t;

  localparam int LINE_STEPS  = 16;
  localparam int GAIN_STEPS  = 15;
  localparam int LTIME_STEPS = 32;
  localparam int RATIO_STEPS = 16;

  // One restoring divider: partial remainder, divisor, dividend bits still
  // to shift in (MSB first), quotient so far, steps left.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] den;
    logic [31:0] num;
    logic [31:0] quo;
    logic [5:0]  cnt;
  } egc_div_t;

  typedef struct packed {
    egc_div_t    a;
    egc_div_t    b;
    logic [23:0] t;
    logic [30:0] n3;
    logic        ovf1;
    logic        ovfg;
    logic        lsat;
    logic        rz;
    logic        gtop;
    logic        need3;
    logic [15:0] lines;
    logic [11:0] grange;
    logic [12:0] gq;
  } egc_item_t;

endpackage

/* sv/egc_in_if.sv */
// Input, output and configuration channel interfaces.
interface egc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] exposure_time;
  logic [15:0] iso_value;
  modport source (output valid, output exposure_time, output iso_value, input ready);
  modport sink (input valid, input exposure_time, input iso_value, output ready);
endinterface

interface egc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] line_count;
  logic [15:0] exposure_ratio;
  logic [11:0] gain_code;
  modport source (output valid, output line_count, output exposure_ratio, output gain_code,
                  input ready);
  modport sink (input valid, input line_count, input exposure_ratio, input gain_code,
                output ready);
endinterface

interface egc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/egc_cell.sv */
// One pipeline cell: a single restoring divide step on each active divider.
module egc_cell import egc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  egc_item_t in_item,
  output logic      in_ready,
  output logic      out_valid,
  output egc_item_t out_item,
  input  logic      out_ready
);

  function automatic egc_div_t div_step(input egc_div_t s);
    logic [32:0] tmp;
    logic [32:0] diff;
    egc_div_t    r;
    r    = s;
    tmp  = {s.rem, s.num[31]};
    diff = tmp - {1'b0, s.den};
    if (s.cnt != 6'd0) begin
      r.num = {s.num[30:0], 1'b0};
      r.cnt = s.cnt - 6'd1;
      if (!diff[32]) begin
        r.rem = diff[31:0];
        r.quo = {s.quo[30:0], 1'b1};
      end else begin
        r.rem = tmp[31:0];
        r.quo = {s.quo[30:0], 1'b0};
      end
    end
    return r;
  endfunction

  egc_item_t item_next;

  always_comb begin
    item_next   = in_item;
    item_next.a = div_step(in_item.a);
    item_next.b = div_step(in_item.b);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_item <= item_next;
    end
  end

endmodule

/* sv/exposure_gain_code_convert_top.sv */
// Top level of the exposure and gain code converter.
//
// Channels: req carries one item (exposure_time, iso_value); rsp returns one
// item (line_count, exposure_ratio, gain_code) per request, in order. cfg
// writes pixel_clock (index 0), line_total (1), agc_base (2), iso_base (3);
// other indexes are dropped. cfg is always ready; write only while idle.
// Throughput: one item per cycle while rsp does not stall, set by chains of
// divider cells, one quotient bit per cell: 16 cells for the line count
// (with the 15-step gain divide alongside), 32 cells for the achieved line
// time, 16 cells for the ratio, with a multiply stage between chains.
// Reset: all stages empty, registers back to 1. When rsp stalls, each stage
// holds its item and fills behind the waiting result; req.ready drops only
// once every stage is full.
module exposure_gain_code_convert_top import egc_pkg::*; (
  input logic clk,
  input logic rst,
  egc_cfg_if.sink  cfg,
  egc_in_if.sink   req,
  egc_out_if.source rsp
);

  // Configuration registers.
  logic [29:0] pixel_clock;
  logic [15:0] line_total;
  logic [15:0] agc_base;
  logic [15:0] iso_base;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_clock <= 30'd1;
      line_total  <= 16'd1;
      agc_base    <= 16'd1;
      iso_base    <= 16'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_PIXEL_CLOCK: pixel_clock <= cfg.data[29:0];
        CFG_LINE_TOTAL:  line_total  <= cfg.data[15:0];
        CFG_AGC_BASE:    agc_base    <= cfg.data[15:0];
        CFG_ISO_BASE:    iso_base    <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  // Stage 0: products of the request.
  logic        s0_v;
  logic [23:0] s0_t;
  logic [53:0] s0_p1;
  logic [31:0] s0_n2;
  logic [30:0] s0_n3;
  logic        s0_rdy;

  // Stage 1: divider setup for line count and gain.
  logic      s1_v;
  egc_item_t s1_d;
  egc_item_t s1_next;
  logic      s1_rdy;

  // Chains of cells; index 0 is the feeding stage.
  logic      c1_v [0:LINE_STEPS];
  egc_item_t c1_d [0:LINE_STEPS];
  logic      c1_rdy [0:LINE_STEPS];
  logic      c2_v [0:LTIME_STEPS];
  egc_item_t c2_d [0:LTIME_STEPS];
  logic      c2_rdy [0:LTIME_STEPS];
  logic      c3_v [0:RATIO_STEPS];
  egc_item_t c3_d [0:RATIO_STEPS];
  logic      c3_rdy [0:RATIO_STEPS];

  logic      g1_v, g2_v;
  egc_item_t g1_d, g2_d, g1_next, g2_next;
  logic      g1_rdy, g2_rdy, g3_rdy;

  // Output register.
  logic        g3_v;
  logic [15:0] g3_lines;
  logic [15:0] g3_ratio;
  logic [11:0] g3_code;

  assign s0_rdy    = !s0_v || s1_rdy;
  assign req.ready = s0_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (s0_rdy) begin
      s0_v <= req.valid;
    end
    if (s0_rdy && req.valid) begin
      s0_t  <= req.exposure_time;
      s0_p1 <= {30'd0, req.exposure_time} * {24'd0, pixel_clock};
      s0_n2 <= {16'd0, agc_base} * {16'd0, req.iso_value};
      s0_n3 <= {7'd0, req.exposure_time} * 31'd100;
    end
  end

  // Quotient fits 16 bits (15 for gain) exactly when the high part is below the divisor.
  always_comb begin
    logic [37:0] hi;
    logic [16:0] hg;
    hi = s0_p1[53:16];
    hg = s0_n2[31:15];
    s1_next        = '0;
    s1_next.t      = s0_t;
    s1_next.n3     = s0_n3;
    s1_next.ovf1   = (line_total == 16'd0) || (hi >= {22'd0, line_total});
    s1_next.ovfg   = (iso_base == 16'd0) || (hg >= {1'b0, iso_base});
    s1_next.a.rem  = s1_next.ovf1 ? 32'd0 : {16'd0, hi[15:0]};
    s1_next.a.den  = {16'd0, line_total};
    s1_next.a.num  = {s0_p1[15:0], 16'd0};
    s1_next.a.cnt  = 6'(LINE_STEPS);
    s1_next.b.rem  = s1_next.ovfg ? 32'd0 : {16'd0, hg[15:0]};
    s1_next.b.den  = {16'd0, iso_base};
    s1_next.b.num  = {s0_n2[14:0], 17'd0};
    s1_next.b.cnt  = 6'(GAIN_STEPS);
  end

  assign s1_rdy = !s1_v || c1_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (s1_rdy) begin
      s1_v <= s0_v;
    end
    if (s1_rdy && s0_v) begin
      s1_d <= s1_next;
    end
  end

  assign c1_v[0] = s1_v;
  assign c1_d[0] = s1_d;
  assign c1_rdy[LINE_STEPS] = g1_rdy;

  for (genvar i = 0; i < LINE_STEPS; i++) begin : g_chain1
    egc_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(c1_v[i]), .in_item(c1_d[i]), .in_ready(c1_rdy[i]),
      .out_valid(c1_v[i+1]), .out_item(c1_d[i+1]), .out_ready(c1_rdy[i+1])
    );
  end

  // Clamp line count and gain; pick gain range; set up line time divide.
  always_comb begin
    egc_item_t   x;
    logic [15:0] lq;
    logic [14:0] qg;
    logic [14:0] g;
    x  = c1_d[LINE_STEPS];
    lq = x.a.quo[15:0];
    qg = x.b.quo[14:0];
    g1_next = x;
    if (x.ovf1) begin
      g1_next.lines = LINE_MAX;
    end else if (lq < LINE_MIN) begin
      g1_next.lines = LINE_MIN;
    end else begin
      g1_next.lines = lq;
    end
    g1_next.lsat = (g1_next.lines == LINE_MAX);
    if (x.ovfg || qg > GAIN_HIGH) begin
      g = GAIN_HIGH;
    end else if (qg < GAIN_LOW) begin
      g = GAIN_LOW;
    end else begin
      g = qg;
    end
    g1_next.gtop  = 1'b0;
    g1_next.need3 = 1'b0;
    if (g < GAIN_B1) begin
      g1_next.grange = RANGE_X1;
      g1_next.gq     = g[12:0];
    end else if (g < GAIN_B2) begin
      g1_next.grange = RANGE_X2;
      g1_next.gq     = g[13:1];
    end else if (g < GAIN_B3) begin
      g1_next.grange = RANGE_X4;
      g1_next.gq     = g[14:2];
    end else if (g < GAIN_B4) begin
      g1_next.grange = RANGE_X6;
      g1_next.gq     = g[13:1];
      g1_next.need3  = 1'b1;
    end else if (g < GAIN_HIGH) begin
      g1_next.grange = RANGE_X12;
      g1_next.gq     = g[14:2];
      g1_next.need3  = 1'b1;
    end else begin
      g1_next.grange = CODE_TOP;
      g1_next.gq     = 13'd0;
      g1_next.gtop   = 1'b1;
    end
    g1_next.a.rem = 32'd0;
    g1_next.a.den = {2'd0, pixel_clock};
    g1_next.a.num = g1_next.lines * line_total;
    g1_next.a.quo = 32'd0;
    g1_next.a.cnt = 6'(LTIME_STEPS);
    g1_next.b.cnt = 6'd0;
  end

  assign g1_rdy = !g1_v || c2_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_v <= 1'b0;
    end else if (g1_rdy) begin
      g1_v <= c1_v[LINE_STEPS];
    end
    if (g1_rdy && c1_v[LINE_STEPS]) begin
      g1_d <= g1_next;
    end
  end

  assign c2_v[0] = g1_v;
  assign c2_d[0] = g1_d;
  assign c2_rdy[LTIME_STEPS] = g2_rdy;

  for (genvar i = 0; i < LTIME_STEPS; i++) begin : g_chain2
    egc_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(c2_v[i]), .in_item(c2_d[i]), .in_ready(c2_rdy[i]),
      .out_valid(c2_v[i+1]), .out_item(c2_d[i+1]), .out_ready(c2_rdy[i+1])
    );
  end

  // Pick achieved line time, set up ratio divide, divide gain by three for x6 and x12.
  always_comb begin
    egc_item_t   x;
    logic [31:0] ltime;
    logic [31:0] rhi;
    logic [28:0] p3;
    x   = c2_d[LTIME_STEPS];
    rhi = {17'd0, x.n3[30:16]};
    if (x.lsat) begin
      ltime = {8'd0, x.t};
    end else if (pixel_clock == 30'd0) begin
      ltime = 32'd0;
    end else begin
      ltime = x.a.quo;
    end
    p3 = x.gq * RECIP3;
    g2_next = x;
    g2_next.rz    = (ltime == 32'd0) || (rhi >= ltime);
    g2_next.a.rem = g2_next.rz ? 32'd0 : rhi;
    g2_next.a.den = ltime;
    g2_next.a.num = {x.n3[15:0], 16'd0};
    g2_next.a.quo = 32'd0;
    g2_next.a.cnt = 6'(RATIO_STEPS);
    if (x.need3) begin
      g2_next.gq = {1'b0, p3[28:17]};
    end
  end

  assign g2_rdy = !g2_v || c3_rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      g2_v <= 1'b0;
    end else if (g2_rdy) begin
      g2_v <= c2_v[LTIME_STEPS];
    end
    if (g2_rdy && c2_v[LTIME_STEPS]) begin
      g2_d <= g2_next;
    end
  end

  assign c3_v[0] = g2_v;
  assign c3_d[0] = g2_d;
  assign c3_rdy[RATIO_STEPS] = g3_rdy;

  for (genvar i = 0; i < RATIO_STEPS; i++) begin : g_chain3
    egc_cell u_cell (
      .clk(clk), .rst(rst),
      .in_valid(c3_v[i]), .in_item(c3_d[i]), .in_ready(c3_rdy[i]),
      .out_valid(c3_v[i+1]), .out_item(c3_d[i+1]), .out_ready(c3_rdy[i+1])
    );
  end

  // Finish ratio saturation and gain code; hold in output register.
  egc_item_t   xo;
  logic [32:0] p4;
  assign xo = c3_d[RATIO_STEPS];
  assign p4 = {xo.gq, 2'b00} * RECIP125;

  assign g3_rdy = !g3_v || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      g3_v <= 1'b0;
    end else if (g3_rdy) begin
      g3_v <= c3_v[RATIO_STEPS];
    end
    if (g3_rdy && c3_v[RATIO_STEPS]) begin
      g3_lines <= xo.lines;
      g3_ratio <= xo.rz ? RATIO_MAX : xo.a.quo[15:0];
      g3_code  <= xo.gtop ? CODE_TOP : ({3'd0, p4[32:24]} | xo.grange);
    end
  end

  assign rsp.valid          = g3_v;
  assign rsp.line_count     = g3_lines;
  assign rsp.exposure_ratio = g3_ratio;
  assign rsp.gain_code      = g3_code;

`include "exposure_gain_code_convert_top_assert.svh"

  `EGC_ASSERT_IMP(a_lines_min, rsp.valid, rsp.line_count >= LINE_MIN, "line count below 2")
  `EGC_ASSERT_IMP(a_code_max, rsp.valid, rsp.gain_code <= CODE_TOP, "gain code above top")
  `EGC_ASSERT_IMP(a_c1_done, c1_v[LINE_STEPS],
                  c1_d[LINE_STEPS].a.cnt == 6'd0 && c1_d[LINE_STEPS].b.cnt == 6'd0,
                  "line divide not finished at chain end")
  `EGC_ASSERT_NXT(a_out_hold, rsp.valid && !rsp.ready && !rst, rsp.valid,
                  "result dropped while stalled")

endmodule

/* tb/exposure_gain_code_convert_top_tb.sv */
// Self-checking testbench for the exposure and gain code converter.
module exposure_gain_code_convert_top_tb;
  import egc_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  egc_cfg_if cfg ();
  egc_in_if  req ();
  egc_out_if rsp ();

  exposure_gain_code_convert_top dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  // 20-unit clock period: high for 10, low for 10.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  typedef struct packed {
    logic [15:0] line_count;
    logic [15:0] exposure_ratio;
    logic [11:0] gain_code;
  } egc_result_t;

  // Working copy of the configuration registers, mirrored on each write.
  logic [29:0] pix_clk_reg;
  logic [15:0] line_tot_reg;
  logic [15:0] agc_base_reg;
  logic [15:0] iso_base_reg;

  egc_result_t pending_results[$];
  int          err_count = 0;
  bit          stim_done = 1'b0;
  bit          idle_on   = 1'b1;

  // Map a clamped gain factor onto the register code.
  function automatic logic [11:0] gain_code_of(logic [63:0] g);
    logic [63:0] div;
    logic [11:0] rng;
    if (g >= 64'(GAIN_HIGH)) return CODE_TOP;
    if (g < 64'(GAIN_B1)) begin
      div = 1; rng = RANGE_X1;
    end else if (g < 64'(GAIN_B2)) begin
      div = 2; rng = RANGE_X2;
    end else if (g < 64'(GAIN_B3)) begin
      div = 4; rng = RANGE_X4;
    end else if (g < 64'(GAIN_B4)) begin
      div = 6; rng = RANGE_X6;
    end else begin
      div = 12; rng = RANGE_X12;
    end
    return 12'(((g / div) * 32) / 1000) | rng;
  endfunction

  // Compute line count, exposure ratio and gain code for one item.
  function automatic egc_result_t convert_exposure(logic [23:0] t, logic [15:0] iso);
    logic [63:0] lines, ltime, ratio, g;
    egc_result_t r;
    if (line_tot_reg == 0) lines = 64'hFFFF;
    else lines = (64'(t) * 64'(pix_clk_reg)) / 64'(line_tot_reg);
    if (lines > 64'hFFFF) lines = 64'hFFFF;
    if (lines < 2) lines = 2;
    if (lines != 64'hFFFF)
      ltime = (pix_clk_reg == 0) ? 64'd0 : (lines * 64'(line_tot_reg)) / 64'(pix_clk_reg);
    else
      ltime = 64'(t);
    if (ltime == 0) ratio = 64'hFFFF;
    else begin
      ratio = (64'(t) * 100) / ltime;
      if (ratio > 64'hFFFF) ratio = 64'hFFFF;
    end
    if (iso_base_reg == 0) g = 64'(GAIN_HIGH);
    else g = ((64'(agc_base_reg) * 100 * 64'(iso)) / 64'(iso_base_reg)) / 100;
    if (g < 64'(GAIN_LOW)) g = 64'(GAIN_LOW);
    if (g > 64'(GAIN_HIGH)) g = 64'(GAIN_HIGH);
    r.line_count     = lines[15:0];
    r.exposure_ratio = ratio[15:0];
    r.gain_code      = gain_code_of(g);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
    err_count++;
  endtask

  // Write one register while the block is idle; mirror it in the predictor.
  task automatic write_reg(egc_cfg_idx_t idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      CFG_PIXEL_CLOCK: pix_clk_reg  = value[29:0];
      CFG_LINE_TOTAL:  line_tot_reg = value[15:0];
      CFG_AGC_BASE:    agc_base_reg = value[15:0];
      CFG_ISO_BASE:    iso_base_reg = value[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(logic [29:0] pc, logic [15:0] lt, logic [15:0] ab,
                           logic [15:0] ib);
    write_reg(CFG_PIXEL_CLOCK, 32'(pc));
    write_reg(CFG_LINE_TOTAL, 32'(lt));
    write_reg(CFG_AGC_BASE, 32'(ab));
    write_reg(CFG_ISO_BASE, 32'(ib));
  endtask

  // Drain: drop valid, wait for all results, then let the pipeline settle.
  task automatic drain();
    req.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // Send one item; hold valid until accepted, with random gaps before it while idling is on.
  // When want_chk is set, check the predictor against a hand-typed result.
  task automatic send_item(logic [23:0] t, logic [15:0] iso, bit want_chk,
                           egc_result_t want);
    egc_result_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    r = convert_exposure(t, iso);
    if (want_chk && r != want) begin
      report_mismatch("typed row", 32'(r), 32'(want));
      r = want;
    end
    req.valid         <= 1'b1;
    req.exposure_time <= t;
    req.iso_value     <= iso;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(r);
  endtask

  // Directed table: time, iso, hand-typed flag and result. Rows run with
  // all registers at their reset value of 1 unless noted by the phase.
  typedef struct {
    logic [23:0] t;
    logic [15:0] iso;
    bit          typed;
    egc_result_t want;
  } egc_row_t;

  egc_row_t reset_rows[5] = '{
    // time 0: two lines, line time 2, ratio 0; gain floor 200 -> 6|0x200
    '{24'd0, 16'd0, 1'b1, '{16'd2, 16'd0, 12'h206}},
    // time 1: two lines, ratio 100*1/2
    '{24'd1, 16'd1, 1'b1, '{16'd2, 16'd50, 12'h206}},
    // upper clamp: line time is the requested time, ratio 100
    '{24'hFFFFFF, 16'hFFFF, 1'b0, '{16'd0, 16'd0, 12'd0}},
    '{24'd65535, 16'd2000, 1'b0, '{16'd0, 16'd0, 12'd0}},
    '{24'd1000, 16'd3999, 1'b0, '{16'd0, 16'd0, 12'd0}}
  };

  // Sink: random stalls; compare each result with the oldest expectation.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("unexpected result at %0t", $time);
          err_count++;
        end else begin
          egc_result_t w;
          w = pending_results.pop_front();
          if (rsp.line_count !== w.line_count)
            report_mismatch("line_count", 32'(rsp.line_count), 32'(w.line_count));
          if (rsp.exposure_ratio !== w.exposure_ratio)
            report_mismatch("exposure_ratio", 32'(rsp.exposure_ratio),
                            32'(w.exposure_ratio));
          if (rsp.gain_code !== w.gain_code)
            report_mismatch("gain_code", 32'(rsp.gain_code), 32'(w.gain_code));
        end
      end
      // Stall in random bursts while idling is on.
      if (idle_on && $urandom_range(0, 9) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) begin
          @(posedge clk);
          if (!rst && rsp.valid && rsp.ready) begin
            $display("result taken while stalled at %0t", $time);
            err_count++;
          end
        end
      end
      rsp.ready <= 1'b1;
    end
  end

  // Stimulus
  initial begin
    egc_result_t none;
    int          n;
    logic [23:0] t;
    logic [15:0] iso;
    none = '0;
    req.valid = 1'b0; req.exposure_time = '0; req.iso_value = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    pix_clk_reg = 1; line_tot_reg = 1; agc_base_reg = 1; iso_base_reg = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at reset.
    foreach (reset_rows[i])
      send_item(reset_rows[i].t, reset_rows[i].iso, reset_rows[i].typed,
                reset_rows[i].want);
    drain();

    // Each gain range, ranges, top code, plus an out-of-list index.
    write_all(30'd1000, 16'd3, 16'd100, 16'd100);
    write_reg(egc_cfg_idx_t'(8'd200), 32'hFFFFFFFF);
    send_item(24'd5, 16'd199, 1'b0, none);
    send_item(24'd7, 16'd1999, 1'b0, none);
    send_item(24'd9, 16'd2000, 1'b0, none);
    send_item(24'd11, 16'd4000, 1'b0, none);
    send_item(24'd13, 16'd8000, 1'b0, none);
    send_item(24'd17, 16'd11999, 1'b0, none);
    send_item(24'd19, 16'd12000, 1'b0, none);
    send_item(24'd23, 16'd23999, 1'b0, none);
    // 24000 and above: top code
    send_item(24'd29, 16'd24000, 1'b1, '{16'd9666, 16'd103, CODE_TOP});
    send_item(24'd0, 16'd65535, 1'b0, none);
    drain();

    // Zero line_total, zero pixel_clock, zero iso_base.
    write_all(30'd0, 16'd0, 16'd65535, 16'd0);
    send_item(24'd123, 16'd5, 1'b1, '{16'hFFFF, 16'd100, CODE_TOP});
    drain();
    write_reg(CFG_LINE_TOTAL, 32'd1);
    send_item(24'd77, 16'd0, 1'b1, '{16'd2, RATIO_MAX, CODE_TOP});
    drain();

    // Extreme registers, ratio overflow.
    write_all(30'h3FFFFFFF, 16'hFFFF, 16'hFFFF, 16'd1);
    send_item(24'hFFFFFF, 16'hFFFF, 1'b0, none);
    send_item(24'd1, 16'd1, 1'b0, none);
    drain();
    write_all(30'd1, 16'hFFFF, 16'd1, 16'hFFFF);
    send_item(24'hFFFFFF, 16'd1, 1'b0, none);
    send_item(24'd40000, 16'hFFFF, 1'b0, none);
    drain();

    // Random phases with fresh settings; last phase runs without idling.
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 3))
        0: write_all(30'($urandom_range(1, 1000000000)), 16'($urandom),
                     16'($urandom), 16'($urandom));
        1: write_all(30'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
                     16'($urandom_range(50, 400)), 16'($urandom_range(50, 400)));
        2: write_all(30'($urandom_range(1000, 100000)), 16'($urandom_range(500, 4000)),
                     16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)));
        default: write_all(30'($urandom), 16'($urandom_range(0, 3)),
                           16'($urandom), 16'($urandom_range(0, 3)));
      endcase
      if (ph == 9) idle_on = 1'b0;
      n = 50;
      repeat (n) begin
        t   = ($urandom_range(0, 1)) ? 24'($urandom) : 24'($urandom_range(0, 5000));
        iso = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        send_item(t, iso, 1'b0, none);
      end
      drain();
    end
    stim_done = 1'b1;
  end

  // Final verdict once all stimulus has completed.
  initial begin
    wait (stim_done);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
